// ===== hdl/link_reconnect_supervisor_core_defines.svh =====
// ----------------------------------------------------------------------------
// link reconnect supervisor: assertion macros
// shared concurrent assertion forms, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef LINK_RECONNECT_SUPERVISOR_CORE_DEFINES_SVH
`define LINK_RECONNECT_SUPERVISOR_CORE_DEFINES_SVH

// same-cycle implication
`define LRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg
// types, codes and register reset values of the link reconnect supervisor
// ----------------------------------------------------------------------------
package lrs_pkg;

  typedef enum logic [3:0] {
    KIND_TICK       = 4'd0,
    KIND_CONNECT    = 4'd1,
    KIND_DISCONNECT = 4'd2,
    KIND_OPENED     = 4'd3,
    KIND_FRAME      = 4'd4,
    KIND_ERROR      = 4'd5,
    KIND_CLOSED     = 4'd6,
    KIND_CREATE_ERR = 4'd7,
    KIND_POLL       = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_OPEN  = 2'd1,
    ACT_CLOSE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    NTF_NONE      = 2'd0,
    NTF_CONNECTED = 2'd1,
    NTF_RECONNECT = 2'd2
  } notify_e;

  typedef enum logic [2:0] {
    LS_DISCONNECTED = 3'd0,
    LS_CONNECTING   = 3'd1,
    LS_OPEN         = 3'd2,
    LS_WAIT_RETRY   = 3'd3,
    LS_RESTART_POLL = 3'd4
  } link_state_e;

  typedef enum logic [1:0] {
    FS_NONE  = 2'd0,
    FS_FRESH = 2'd1,
    FS_STALE = 2'd2
  } frame_state_e;

  typedef enum logic [1:0] {
    RS_CONNECTING = 2'd0,
    RS_OPEN       = 2'd1,
    RS_CLOSING    = 2'd2,
    RS_CLOSED     = 2'd3
  } ready_state_e;

  typedef enum logic [2:0] {
    REG_BASE_DELAY      = 3'd0,
    REG_MAX_DELAY       = 3'd1,
    REG_CONNECT_TIMEOUT = 3'd2,
    REG_STABLE          = 3'd3,
    REG_RESTART_POLL    = 3'd4,
    REG_RESTART_GRACE   = 3'd5,
    REG_DEFAULT_ETA     = 3'd6,
    REG_STALE_FRAME     = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;

  localparam logic [2:0]  FailCap     = 3'd6;
  localparam logic [15:0] RestartCode = 16'd1001;
  localparam logic [9:0]  MsPerSec    = 10'd1000;

  localparam logic [15:0] BaseDelayRst      = 16'd1000;
  localparam logic [21:0] MaxDelayRst       = 22'd30000;
  localparam logic [19:0] ConnectTimeoutRst = 20'd15000;
  localparam logic [19:0] StableRst         = 20'd10000;
  localparam logic [15:0] RestartPollRst    = 16'd2000;
  localparam logic [19:0] RestartGraceRst   = 20'd45000;
  localparam logic [9:0]  DefaultEtaRst     = 10'd45;
  localparam logic [19:0] StaleFrameRst     = 20'd15000;

  typedef struct packed {
    logic [3:0]         kind;
    logic [3:0]         event_socket;
    logic [1:0]         ready_state;
    logic               query_ok;
    logic               binary_nonempty;
    logic [15:0]        close_code;
    logic               reason_is_restart;
    logic signed [15:0] eta_s;
  } evt_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  socket_id;
    logic        connected;
    logic [2:0]  link_state;
    logic [1:0]  notify;
    logic [2:0]  retry_count;
    logic        accepted;
    logic        restart_reconnected;
    logic [31:0] outage_ms;
    logic [1:0]  frame_state;
  } res_t;

  typedef struct packed {
    logic [15:0] base_delay_ms;
    logic [21:0] max_delay_ms;
    logic [19:0] connect_timeout_ms;
    logic [19:0] stable_ms;
    logic [15:0] restart_poll_ms;
    logic [19:0] restart_grace_ms;
    logic [9:0]  default_eta_s;
    logic [19:0] stale_frame_ms;
  } cfg_t;

endpackage

// ===== hdl/lrs_stream_if.sv =====
// ----------------------------------------------------------------------------
// lrs_stream_if
// valid/ready channel; a transfer takes place when valid and ready are high
// ----------------------------------------------------------------------------
interface lrs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/lrs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lrs_cfg_regs
// configuration register file, written through a plain indexed write port
// ----------------------------------------------------------------------------
module lrs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lrs_pkg::CfgDataW-1:0]  cfg_data_i,
  output lrs_pkg::cfg_t                 cfg_o
);

  lrs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrs_pkg::REG_BASE_DELAY:      cfg_d.base_delay_ms      = cfg_data_i[15:0];
        lrs_pkg::REG_MAX_DELAY:       cfg_d.max_delay_ms       = cfg_data_i[21:0];
        lrs_pkg::REG_CONNECT_TIMEOUT: cfg_d.connect_timeout_ms = cfg_data_i[19:0];
        lrs_pkg::REG_STABLE:          cfg_d.stable_ms          = cfg_data_i[19:0];
        lrs_pkg::REG_RESTART_POLL:    cfg_d.restart_poll_ms    = cfg_data_i[15:0];
        lrs_pkg::REG_RESTART_GRACE:   cfg_d.restart_grace_ms   = cfg_data_i[19:0];
        lrs_pkg::REG_DEFAULT_ETA:     cfg_d.default_eta_s      = cfg_data_i[9:0];
        lrs_pkg::REG_STALE_FRAME:     cfg_d.stale_frame_ms     = cfg_data_i[19:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_delay_ms      <= lrs_pkg::BaseDelayRst;
      cfg_q.max_delay_ms       <= lrs_pkg::MaxDelayRst;
      cfg_q.connect_timeout_ms <= lrs_pkg::ConnectTimeoutRst;
      cfg_q.stable_ms          <= lrs_pkg::StableRst;
      cfg_q.restart_poll_ms    <= lrs_pkg::RestartPollRst;
      cfg_q.restart_grace_ms   <= lrs_pkg::RestartGraceRst;
      cfg_q.default_eta_s      <= lrs_pkg::DefaultEtaRst;
      cfg_q.stale_frame_ms     <= lrs_pkg::StaleFrameRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/lrs_engine.sv =====
// ----------------------------------------------------------------------------
// lrs_engine
// supervisor state and single-pass next-state logic; one event per step
// ----------------------------------------------------------------------------
`include "link_reconnect_supervisor_core_defines.svh"

module lrs_engine #(
  parameter int unsigned MAX_SHIFT = 5,
  parameter int unsigned MAX_ETA_S = 600
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lrs_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  lrs_pkg::evt_t evt_i,
  output lrs_pkg::res_t res_o
);

  localparam int unsigned SW  = $clog2(MAX_SHIFT + 1);
  localparam int unsigned DW  = 16 + MAX_SHIFT;
  localparam int unsigned LW  = (DW > 22) ? DW : 22;
  localparam int unsigned EAW = $clog2(MAX_ETA_S + 1);
  localparam int unsigned EW  = (EAW > 10) ? EAW : 10;
  localparam int unsigned PW  = EW + 10;

  function automatic logic [31:0] sat32(input logic [32:0] s);
    sat32 = s[32] ? '1 : s[31:0];
  endfunction

  // state
  logic [31:0] time_q, time_d;
  logic        enabled_q, enabled_d;
  logic        present_q, present_d;
  logic [3:0]  number_q, number_d;
  logic        link_q, link_d;
  logic [2:0]  failures_q, failures_d;
  logic [31:0] retry_q, retry_d;
  logic [31:0] conn_start_q, conn_start_d;
  logic [31:0] open_start_q, open_start_d;
  logic        pending_q, pending_d;
  logic [31:0] rst_start_q, rst_start_d;
  logic [31:0] rst_end_q, rst_end_d;
  logic        fseen_q, fseen_d;
  logic [31:0] ftime_q, ftime_d;
  logic [31:0] outage_q, outage_d;

  // shared terms
  logic          match;
  logic [31:0]   time_inc;
  logic [3:0]    number_nxt;
  logic          eta_ok;
  logic [EW-1:0] eta_val;
  logic [PW-1:0] eta_ms;
  logic [31:0]   rst_end_new;
  logic          restart_new_act;
  logic          restart_old_act;
  logic [SW-1:0] sh;
  logic [DW-1:0] shifted;
  logic [LW-1:0] delay;
  logic [31:0]   retry_backoff;
  logic [31:0]   retry_poll;
  logic [2:0]    fail_inc;
  logic          conn_timed_out;
  logic          open_stable;

  assign match      = present_q && (evt_i.event_socket == number_q);
  assign time_inc   = (&time_q) ? time_q : time_q + 32'd1;
  assign number_nxt = (number_q + 4'd1 == 4'd0) ? 4'd1 : number_q + 4'd1;

  assign eta_ok  = (evt_i.eta_s > 16'sd0) && (evt_i.eta_s <= $signed(16'(MAX_ETA_S)));
  assign eta_val = eta_ok ? EW'($unsigned(evt_i.eta_s)) : EW'(cfg_i.default_eta_s);
  assign eta_ms  = PW'(eta_val) * PW'(lrs_pkg::MsPerSec);
  assign rst_end_new = sat32({1'b0, time_q} + 33'(eta_ms));

  // a freshly announced window is open unless the time counter is saturated with no grace
  assign restart_new_act = !((cfg_i.restart_grace_ms == '0) && (&time_q));
  assign restart_old_act = pending_q &&
         ({1'b0, time_q} < ({1'b0, rst_end_q} + 33'(cfg_i.restart_grace_ms)));

  assign sh      = (32'(failures_q) < 32'(MAX_SHIFT)) ? SW'(failures_q) : SW'(MAX_SHIFT);
  assign shifted = DW'(cfg_i.base_delay_ms) << sh;
  assign delay   = (LW'(shifted) > LW'(cfg_i.max_delay_ms)) ? LW'(cfg_i.max_delay_ms)
                                                              : LW'(shifted);
  assign retry_backoff = sat32({1'b0, time_q} + 33'(delay));
  assign retry_poll    = sat32({1'b0, time_q} + 33'(cfg_i.restart_poll_ms));
  assign fail_inc      = (failures_q < lrs_pkg::FailCap) ? failures_q + 3'd1
                                                         : lrs_pkg::FailCap;

  assign conn_timed_out = (time_q - conn_start_q) >= 32'(cfg_i.connect_timeout_ms);
  assign open_stable    = (time_q - open_start_q) >= 32'(cfg_i.stable_ms);

  logic                  sched;
  logic                  restart_now;
  logic                  sched_restart;
  logic                  final_restart;
  lrs_pkg::action_e      act;
  lrs_pkg::notify_e      ntf;
  lrs_pkg::link_state_e  lstate;
  lrs_pkg::frame_state_e fstate;
  logic                  acc;
  logic                  reconn;

  always_comb begin
    time_d       = time_q;
    enabled_d    = enabled_q;
    present_d    = present_q;
    number_d     = number_q;
    link_d       = link_q;
    failures_d   = failures_q;
    retry_d      = retry_q;
    conn_start_d = conn_start_q;
    open_start_d = open_start_q;
    pending_d    = pending_q;
    rst_start_d  = rst_start_q;
    rst_end_d    = rst_end_q;
    fseen_d      = fseen_q;
    ftime_d      = ftime_q;
    outage_d     = outage_q;
    act          = lrs_pkg::ACT_NONE;
    ntf          = lrs_pkg::NTF_NONE;
    acc          = 1'b0;
    reconn       = 1'b0;
    sched        = 1'b0;
    restart_now  = 1'b0;

    if (step_i) begin
      unique case (evt_i.kind)
        lrs_pkg::KIND_TICK: begin
          time_d = time_inc;
        end
        lrs_pkg::KIND_CONNECT: begin
          if (!enabled_q) begin
            enabled_d    = 1'b1;
            failures_d   = '0;
            acc          = 1'b1;
            act          = lrs_pkg::ACT_OPEN;
            conn_start_d = time_q;
            number_d     = number_nxt;
            present_d    = 1'b1;
          end
        end
        lrs_pkg::KIND_DISCONNECT: begin
          enabled_d = 1'b0;
          act       = present_q ? lrs_pkg::ACT_CLOSE : lrs_pkg::ACT_NONE;
          present_d = 1'b0;
          link_d    = 1'b0;
          retry_d   = '0;
          fseen_d   = 1'b0;
        end
        lrs_pkg::KIND_OPENED: begin
          if (match && enabled_q) begin
            link_d       = 1'b1;
            open_start_d = time_q;
            fseen_d      = 1'b0;
            ntf          = lrs_pkg::NTF_CONNECTED;
            if (pending_q) begin
              outage_d  = time_q - rst_start_q;
              reconn    = 1'b1;
              pending_d = 1'b0;
            end
          end
        end
        lrs_pkg::KIND_FRAME: begin
          if (match && link_q && evt_i.binary_nonempty) begin
            fseen_d = 1'b1;
            ftime_d = time_q;
          end
        end
        lrs_pkg::KIND_ERROR: begin
          if (match) begin
            sched = 1'b1;
            act   = lrs_pkg::ACT_CLOSE;
          end
        end
        lrs_pkg::KIND_CLOSED: begin
          if (match) begin
            if ((evt_i.close_code == lrs_pkg::RestartCode) && evt_i.reason_is_restart) begin
              restart_now = 1'b1;
              pending_d   = 1'b1;
              rst_start_d = time_q;
              rst_end_d   = rst_end_new;
            end
            sched = 1'b1;
            act   = lrs_pkg::ACT_CLOSE;
          end
        end
        lrs_pkg::KIND_CREATE_ERR: begin
          if (match) begin
            sched = 1'b1;
          end
        end
        lrs_pkg::KIND_POLL: begin
          if (enabled_q) begin
            if (present_q) begin
              if (!evt_i.query_ok || (evt_i.ready_state == lrs_pkg::RS_CLOSING) ||
                  (evt_i.ready_state == lrs_pkg::RS_CLOSED) ||
                  (!link_q && conn_timed_out)) begin
                sched = 1'b1;
                act   = lrs_pkg::ACT_CLOSE;
              end else if (link_q && open_stable) begin
                failures_d = '0;
              end
            end else if (time_q >= retry_q) begin
              act          = lrs_pkg::ACT_OPEN;
              conn_start_d = time_q;
              number_d     = number_nxt;
              present_d    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // drop the socket and, while enabled, book the next attempt
    sched_restart = restart_now ? restart_new_act : restart_old_act;
    if (sched) begin
      present_d = 1'b0;
      link_d    = 1'b0;
      if (enabled_q) begin
        if (sched_restart) begin
          retry_d = retry_poll;
        end else begin
          retry_d    = retry_backoff;
          failures_d = fail_inc;
        end
        ntf = lrs_pkg::NTF_RECONNECT;
      end
    end

    final_restart = restart_now ? restart_new_act :
                    (!link_d && pending_d &&
                     ({1'b0, time_d} < ({1'b0, rst_end_q} + 33'(cfg_i.restart_grace_ms))));

    if (link_d) begin
      lstate = lrs_pkg::LS_OPEN;
    end else if (!enabled_d) begin
      lstate = lrs_pkg::LS_DISCONNECTED;
    end else if (final_restart) begin
      lstate = lrs_pkg::LS_RESTART_POLL;
    end else if (present_d) begin
      lstate = lrs_pkg::LS_CONNECTING;
    end else begin
      lstate = lrs_pkg::LS_WAIT_RETRY;
    end

    if (!fseen_d) begin
      fstate = lrs_pkg::FS_NONE;
    end else if ((time_d - ftime_d) >= 32'(cfg_i.stale_frame_ms)) begin
      fstate = lrs_pkg::FS_STALE;
    end else begin
      fstate = lrs_pkg::FS_FRESH;
    end
  end

  assign res_o.action              = act;
  assign res_o.socket_id           = present_d ? number_d : 4'd0;
  assign res_o.connected           = link_d;
  assign res_o.link_state          = lstate;
  assign res_o.notify              = ntf;
  assign res_o.retry_count         = failures_d;
  assign res_o.accepted            = acc;
  assign res_o.restart_reconnected = reconn;
  assign res_o.outage_ms           = outage_d;
  assign res_o.frame_state         = fstate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q       <= '0;
      enabled_q    <= 1'b0;
      present_q    <= 1'b0;
      number_q     <= '0;
      link_q       <= 1'b0;
      failures_q   <= '0;
      retry_q      <= '0;
      conn_start_q <= '0;
      open_start_q <= '0;
      pending_q    <= 1'b0;
      rst_start_q  <= '0;
      rst_end_q    <= '0;
      fseen_q      <= 1'b0;
      ftime_q      <= '0;
      outage_q     <= '0;
    end else if (step_i) begin
      time_q       <= time_d;
      enabled_q    <= enabled_d;
      present_q    <= present_d;
      number_q     <= number_d;
      link_q       <= link_d;
      failures_q   <= failures_d;
      retry_q      <= retry_d;
      conn_start_q <= conn_start_d;
      open_start_q <= open_start_d;
      pending_q    <= pending_d;
      rst_start_q  <= rst_start_d;
      rst_end_q    <= rst_end_d;
      fseen_q      <= fseen_d;
      ftime_q      <= ftime_d;
      outage_q     <= outage_d;
    end
  end

  `LRS_ASSERT_IMP(a_sock_nonzero, clk_i, rst_ni, present_q, number_q != 4'd0, "socket 0 in use")
  `LRS_ASSERT_IMP(a_open_has_sock, clk_i, rst_ni, link_q, present_q && enabled_q, "open link without socket")
  `LRS_ASSERT_IMP(a_fail_cap, clk_i, rst_ni, 1'b1, failures_q <= lrs_pkg::FailCap, "failure count over cap")
  `LRS_ASSERT_NXT(a_time_tick_only, clk_i, rst_ni, !(step_i && (evt_i.kind == lrs_pkg::KIND_TICK)), $stable(time_q), "clock moved without tick")

endmodule

// ===== hdl/link_reconnect_supervisor_core.sv =====
// ----------------------------------------------------------------------------
// link_reconnect_supervisor_core
// connection supervisor with capped exponential backoff and restart polling
// ----------------------------------------------------------------------------
// Each event transfer gives exactly one result transfer. An accepted event
// is held in the input register, is evaluated against the supervisor state
// in a single pass, and its result is loaded into the output register once
// that register is empty or being taken, and is offered from there. The core
// takes one event per clock for as long as the result side keeps taking;
// the engine state is updated on the same edge that loads the result.
// The user must write configuration through cfg_we_i/cfg_idx_i/cfg_data_i
// only while no event is in flight; the core does not enforce this, and
// there is no start-up sweep.
module link_reconnect_supervisor_core #(
  parameter int unsigned MAX_SHIFT = 5,
  parameter int unsigned MAX_ETA_S = 600
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lrs_pkg::CfgDataW-1:0] cfg_data_i,
  lrs_stream_if.sink                   evt_i,
  lrs_stream_if.source                 res_o
);

  lrs_pkg::cfg_t cfg;
  lrs_pkg::evt_t evt_q;
  lrs_pkg::res_t res_q;
  lrs_pkg::res_t res_d;
  logic          evt_vld_q;
  logic          res_vld_q;
  logic          adv;

  lrs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lrs_engine #(
    .MAX_SHIFT (MAX_SHIFT),
    .MAX_ETA_S (MAX_ETA_S)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (adv),
    .evt_i  (evt_q),
    .res_o  (res_d)
  );

  // move the held event into the result register
  assign adv         = evt_vld_q && (!res_vld_q || res_o.ready);
  assign evt_i.ready = !evt_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (evt_i.valid && evt_i.ready) begin
        evt_vld_q <= 1'b1;
      end else if (adv) begin
        evt_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      evt_q <= evt_i.payload;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = res_vld_q;
  assign res_o.payload = res_q;

endmodule
